### rtl/fir_lp_pkg.sv
package fir_lp_pkg;

   // default configuration
   localparam int DEF_TAP_COUNT      = 59;
   localparam int DEF_SAMPLE_BITS    = 16;
   localparam int DEF_COEF_FRAC_BITS = 17;

   // coefficient format: signed, 17 fraction bits
   localparam int COEF_BITS  = 18;
   localparam int TABLE_TAPS = 59;

   typedef logic signed [COEF_BITS-1:0] coef_type;

   // symmetric low-pass taps, scaled by 2^17 and rounded
   localparam coef_type COEF_TABLE [TABLE_TAPS] = '{
          18'sd0,     -18'sd2,     -18'sd6,     -18'sd9,      18'sd0,
         18'sd30,     18'sd75,    18'sd111,     18'sd97,      18'sd0,
       -18'sd182,   -18'sd390,   -18'sd508,   -18'sd404,      18'sd0,
        18'sd644,   18'sd1297,   18'sd1604,   18'sd1219,      18'sd0,
      -18'sd1828,  -18'sd3624,  -18'sd4462,  -18'sd3431,      18'sd0,
       18'sd5674,  18'sd12663,  18'sd19459,  18'sd24403,  18'sd26211,
      18'sd24403,  18'sd19459,  18'sd12663,   18'sd5674,      18'sd0,
      -18'sd3431,  -18'sd4462,  -18'sd3624,  -18'sd1828,      18'sd0,
       18'sd1219,   18'sd1604,   18'sd1297,    18'sd644,      18'sd0,
       -18'sd404,   -18'sd508,   -18'sd390,   -18'sd182,      18'sd0,
         18'sd97,    18'sd111,     18'sd75,     18'sd30,      18'sd0,
         -18'sd9,     -18'sd6,     -18'sd2,      18'sd0
   };

   // taps past the end of the table weigh zero
   function automatic coef_type coef_at(input int idx);
      coef_type c;
      c = '0;
      if (idx >= 0 && idx < TABLE_TAPS) begin
         c = COEF_TABLE[idx];
      end
      return c;
   endfunction

   // status of the result register
   typedef struct packed {
      logic valid;
      logic ready;
   } rsp_status_type;

endpackage

### rtl/fir_lp_cell.sv
module fir_lp_cell #(
   parameter int TAP_INDEX   = 0,
   parameter int SAMPLE_BITS = 16,
   parameter int ACC_BITS    = 40
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       shift_en,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic signed [ACC_BITS-1:0]    sum_in,
   output logic signed [ACC_BITS-1:0]    sum_out
);
   import fir_lp_pkg::*;

   localparam coef_type COEF = coef_at(TAP_INDEX);
   localparam int PROD_BITS  = SAMPLE_BITS + COEF_BITS;

   logic signed [PROD_BITS-1:0] prod;
   logic signed [ACC_BITS-1:0]  sum_ff;
   logic signed [ACC_BITS-1:0]  sum_in_w;

   // partial sum of this tap plus everything upstream
   assign prod     = sample * COEF;
   assign sum_in_w = sum_in + ACC_BITS'(prod);

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else if (shift_en) begin
         sum_ff <= sum_in_w;
      end
   end

   assign sum_out = sum_ff;

endmodule

### rtl/fir_lp_outstage.sv
module fir_lp_outstage #(
   parameter int SAMPLE_BITS    = 16,
   parameter int COEF_FRAC_BITS = 17,
   parameter int ACC_BITS       = 40,
   parameter int DATA_BITS      = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       load,
   input  logic                       rsp_tready,
   input  logic signed [ACC_BITS-1:0] acc,
   output fir_lp_pkg::rsp_status_type status,
   output logic [DATA_BITS-1:0]       rsp_tdata
);
   import fir_lp_pkg::*;

   localparam int W = ACC_BITS + 1;
   localparam logic signed [W-1:0] HALF = W'(64'd1 << (COEF_FRAC_BITS - 1));
   localparam logic signed [W-1:0] HI   =
      {{(W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
   localparam logic signed [W-1:0] LO   = ~HI;

   logic                   valid_ff;
   logic                   valid_in;
   logic signed [W-1:0]    rounded;
   logic signed [W-1:0]    shifted;
   logic [SAMPLE_BITS-1:0] result;

   // result stays put in the last cell until the next beat is taken
   assign rounded = W'(acc) + HALF;
   assign shifted = rounded >>> COEF_FRAC_BITS;

   // saturate to the sample range
   always_comb begin
      if (shifted > HI) begin
         result = HI[SAMPLE_BITS-1:0];
      end else if (shifted < LO) begin
         result = LO[SAMPLE_BITS-1:0];
      end else begin
         result = shifted[SAMPLE_BITS-1:0];
      end
   end

   // valid flag of the result beat
   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign status.valid = valid_ff;
   assign status.ready = !valid_ff || rsp_tready;
   assign rsp_tdata    = DATA_BITS'(result);

endmodule

### rtl/fir_lowpass_filter_core.sv
// Transposed-form low-pass FIR, TAP_COUNT fixed symmetric taps (59 by default),
// built as a transposed chain of tap cells: each accepted sample is
// multiplied by every coefficient at once and added into the partial sum
// handed on by the neighboring cell, so the last cell holds the full sum.
// One sample is accepted per clock unless an untaken result stalls it; its
// filtered result is presented in the cycle after the input beat and held in
// an output register until taken, while the next sample may enter in the
// same cycle. The sum is kept at full precision, rounded to nearest (ties
// up), shifted right COEF_FRAC_BITS and saturated to the signed sample
// range. Reset clears the chain, which acts as a history of zero samples.
module fir_lowpass_filter_core #(
   parameter int TAP_COUNT      = fir_lp_pkg::DEF_TAP_COUNT,
   parameter int SAMPLE_BITS    = fir_lp_pkg::DEF_SAMPLE_BITS,
   parameter int COEF_FRAC_BITS = fir_lp_pkg::DEF_COEF_FRAC_BITS,
   parameter int DATA_BITS      = ((SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [DATA_BITS-1:0] req_tdata,   // sample
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [DATA_BITS-1:0] rsp_tdata    // filtered
);
   import fir_lp_pkg::*;

   localparam int ACC_BITS = SAMPLE_BITS + COEF_BITS + $clog2(TAP_COUNT + 1);

   rsp_status_type                 status;
   logic                           accept;
   logic signed [SAMPLE_BITS-1:0]  sample;
   logic signed [ACC_BITS-1:0]     chain_sum [TAP_COUNT+1];

   assign sample = signed'(req_tdata[SAMPLE_BITS-1:0]);
   assign accept = req_tvalid && req_tready;

   // far end of the chain feeds zero
   assign chain_sum[TAP_COUNT] = '0;

   // tap cells, highest tap first
   for (genvar k = 0; k < TAP_COUNT; k++) begin : g_cell
      fir_lp_cell #(
         .TAP_INDEX   (k),
         .SAMPLE_BITS (SAMPLE_BITS),
         .ACC_BITS    (ACC_BITS)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (accept),
         .sample   (sample),
         .sum_in   (chain_sum[k+1]),
         .sum_out  (chain_sum[k])
      );
   end

   // rounding, saturation and result beat
   fir_lp_outstage #(
      .SAMPLE_BITS    (SAMPLE_BITS),
      .COEF_FRAC_BITS (COEF_FRAC_BITS),
      .ACC_BITS       (ACC_BITS),
      .DATA_BITS      (DATA_BITS)
   ) u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .rsp_tready (rsp_tready),
      .acc        (chain_sum[0]),
      .status     (status),
      .rsp_tdata  (rsp_tdata)
   );

   assign req_tready = status.ready;
   assign rsp_tvalid = status.valid;

   // every accepted sample yields a result beat
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_tvalid)
      else $error("accepted sample produced no result beat");

   // a waiting result is never overwritten by a new sample
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !accept)
      else $error("sample accepted while result still pending");

   // reset leaves no result pending
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule
